// ----- rtl/iad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iad_pkg
// Shared constants, controller/datapath signal groups and elaboration helpers
// for the integer to ASCII digits converter.
// ----------------------------------------------------------------------------
package iad_pkg;

    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_LC_A  = 7'h61;

    localparam int MAX_DEC_DIGITS = 20;

    typedef struct packed {
        logic load;
        logic sign_emit;
        logic dec_step;
        logic hex_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic bit_zero;
        logic pos_zero;
        logic in_neg;
    } t_stat;

    // power of ten, evaluated at elaboration only
    function automatic logic [63:0] iad_pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // decimal digits needed for the largest unsigned value of the width
    function automatic int iad_dec_digits(input int width);
        logic [63:0] maxv;
        logic [63:0] p;
        int          n;
        maxv = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        p    = 64'd10;
        n    = 1;
        while (n < MAX_DEC_DIGITS && p <= maxv) begin
            p = p * 64'd10;
            n = n + 1;
        end
        return n;
    endfunction

    function automatic logic [6:0] iad_hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = CHAR_ZERO + {3'b000, nib};
        end else begin
            c = CHAR_LC_A + {3'b000, nib - 4'd10};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/iad_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iad_ctrl
// Sequencer for one conversion: sign, decimal trial subtraction steps or
// hex nibble steps, pacing each character against the output register.
// ----------------------------------------------------------------------------
module iad_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_operation,
    input  wire iad_pkg::t_stat i_stat,
    output iad_pkg::t_cmd      o_cmd
);
    import iad_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIGN,
        S_DEC,
        S_HEX
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    priority if (i_operation == OP_UDEC) begin
                        n_state = S_DEC;
                    end else if (i_operation == OP_SDEC) begin
                        n_state = i_stat.in_neg ? S_SIGN : S_DEC;
                    end else if (i_operation == OP_HEX) begin
                        n_state = S_HEX;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SIGN: begin
                o_cmd.sign_emit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.dec_step = !i_stat.bit_zero || i_stat.out_free;
                if (i_stat.bit_zero && i_stat.out_free && i_stat.pos_zero) begin
                    n_state = S_IDLE;
                end
            end
            S_HEX: begin
                o_cmd.hex_step = i_stat.out_free;
                if (i_stat.out_free && i_stat.pos_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/iad_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iad_dpath
// Remainder register with one trial subtraction per cycle against a shifted
// power of ten (pausing at a digit's last step while the output register is
// full), hex nibble shifter, digit position counter and output word register.
// ----------------------------------------------------------------------------
module iad_dpath #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_operation,
    input  wire logic [31:0]   i_value,
    input  wire iad_pkg::t_cmd i_cmd,
    output iad_pkg::t_stat     o_stat,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [6:0]         o_character,
    output logic               o_last_char
);
    import iad_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int D  = iad_dec_digits(VW);
    localparam int H  = (VW + 3) / 4;
    localparam int HW = 4 * H;
    localparam int CW = VW + 4;
    localparam int PW = $clog2(D);

    logic [VW-1:0] pow_tab [D];

    for (genvar g = 0; g < D; g++) begin : g_pow
        assign pow_tab[g] = VW'(iad_pow10(g));
    end

    logic [HW-1:0] r_rem;
    logic [PW-1:0] r_pos;
    logic [1:0]    r_bit;
    logic [3:0]    r_digit;
    logic          r_started;
    logic          r_out_valid;
    logic [6:0]    r_out_char;
    logic          r_out_last;

    logic [VW-1:0] v_in;
    logic          neg_sel;
    logic [VW-1:0] mag;
    logic [CW-1:0] pow_sh;
    logic [CW-1:0] diff;
    logic          ge;
    logic [HW-1:0] rem_sub;
    logic [3:0]    digit_next;
    logic          dec_emit;
    logic [3:0]    nib;
    logic          hex_emit;
    logic          out_free;
    logic          out_load;
    logic [6:0]    out_char;
    logic          out_last;

    assign v_in    = VW'(i_value);
    assign neg_sel = (i_operation == OP_SDEC) && v_in[VW-1];
    assign mag     = neg_sel ? (~v_in + VW'(1)) : v_in;

    // one trial subtraction of power << bit
    assign pow_sh     = CW'(pow_tab[r_pos]) << r_bit;
    assign diff       = CW'(r_rem) - pow_sh;
    assign ge         = !diff[CW-1];
    assign rem_sub    = ge ? HW'(diff) : r_rem;
    assign digit_next = r_digit | (ge ? (4'd1 << r_bit) : 4'd0);
    assign dec_emit   = r_started || (digit_next != 4'd0) || o_stat.pos_zero;

    assign nib      = r_rem[HW-1 -: 4];
    assign hex_emit = r_started || (nib != 4'd0) || o_stat.pos_zero;

    assign out_free = !r_out_valid || i_ready;

    assign o_stat.out_free = out_free;
    assign o_stat.bit_zero = (r_bit == 2'd0);
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.in_neg   = v_in[VW-1];

    always_comb begin
        out_load = 1'b0;
        out_char = CHAR_MINUS;
        out_last = 1'b0;
        if (i_cmd.sign_emit) begin
            out_load = 1'b1;
        end else if (i_cmd.dec_step && o_stat.bit_zero) begin
            out_load = dec_emit;
            out_char = CHAR_ZERO + {3'b000, digit_next};
            out_last = o_stat.pos_zero;
        end else if (i_cmd.hex_step) begin
            out_load = hex_emit;
            out_char = iad_hex_char(nib);
            out_last = o_stat.pos_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem     <= HW'(mag);
            r_pos     <= (i_operation == OP_HEX) ? PW'(H - 1) : PW'(D - 1);
            r_bit     <= 2'd3;
            r_digit   <= 4'd0;
            r_started <= 1'b0;
        end else if (i_cmd.dec_step) begin
            r_rem <= rem_sub;
            if (o_stat.bit_zero) begin
                r_pos     <= r_pos - PW'(1);
                r_bit     <= 2'd3;
                r_digit   <= 4'd0;
                r_started <= dec_emit;
            end else begin
                r_bit   <= r_bit - 2'd1;
                r_digit <= digit_next;
            end
        end else if (i_cmd.hex_step) begin
            r_rem     <= r_rem << 4;
            r_pos     <= r_pos - PW'(1);
            r_started <= hex_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char <= out_char;
            r_out_last <= out_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last_char = r_out_last;

endmodule
`default_nettype wire

// ----- rtl/integer_to_ascii_digits_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Converts one number per input word into ASCII characters, most significant
// first, one character per output word with o_last_char on the final one.
//
// Input channel: i_valid/o_ready carry i_operation (0 unsigned decimal,
// 1 signed decimal, 2 lower-case hex) and i_value. Operation code 3 is taken
// and produces no output. Output channel: o_valid/i_ready carry o_character
// and o_last_char through a single output register.
// Decimal: one trial subtraction of a shifted power of ten per cycle, one per
// digit bit from the highest, pausing at a position's last bit while the
// output register is full; VALUE_WIDTH-dependent positions (10 at 32 bits).
// Hex: one nibble per cycle while the output register is free to take it.
// The first character is registered once the steps reach the first position
// shown, or first of all a minus sign when there is one.
// A new word is taken once the previous one has all characters written into
// the output register; the last character may still wait there.
// A stalled receiver holds the output register; conversion halts at the next
// digit position, shown or not, until it drains.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_character,
    output logic             o_last_char
);
    import iad_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    iad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    iad_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    a_cmd_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.sign_emit, cmd.dec_step, cmd.hex_step}))
        else $error("more than one datapath command");

    a_load_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> o_ready)
        else $error("load while busy");

    a_sign_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sign_emit |=> (o_valid && (o_character == CHAR_MINUS) && !o_last_char))
        else $error("minus word not presented");

    a_hex_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.hex_step && stat.pos_zero) |=> (o_valid && o_last_char))
        else $error("last hex word missing");

endmodule
`default_nettype wire

// ----- verif/integer_to_ascii_digits_top_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top_tb
// Self-checking bench for the integer to ASCII digits converter. Numbers of
// every conversion kind go in over the input handshake. Each accepted number
// is expanded here into the characters it should produce, and every output
// word is compared with the oldest character still owed. The run starts with
// directed edge values and then moves to random values across four phases of
// sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 97;

    typedef struct {
        logic [6:0] ch;
        logic       last_flag;
    } t_char_word;

    class ascii_scoreboard;
        t_char_word pending_chars[$];
        int         mismatches;
        int         chars_checked;
        int         numbers_noted;

        function new();
            mismatches    = 0;
            chars_checked = 0;
            numbers_noted = 0;
        endfunction

        // expands one accepted number into the characters it owes
        function void note_number(logic [1:0] op, logic [31:0] val);
            logic [31:0] mag;
            logic [3:0]  nib;
            logic [6:0]  digits[$];
            bit          neg;
            t_char_word  w;
            numbers_noted++;
            neg = 1'b0;
            mag = val;
            case (op)
                iad_pkg::OP_UDEC, iad_pkg::OP_SDEC: begin
                    if (op == iad_pkg::OP_SDEC && val[31]) begin
                        neg = 1'b1;
                        mag = -val;
                    end
                    if (mag == 32'd0) begin
                        digits.push_back(iad_pkg::CHAR_ZERO);
                    end
                    while (mag != 32'd0) begin
                        digits.push_front(iad_pkg::CHAR_ZERO + 7'(mag % 32'd10));
                        mag = mag / 32'd10;
                    end
                end
                iad_pkg::OP_HEX: begin
                    if (mag == 32'd0) begin
                        digits.push_back(iad_pkg::CHAR_ZERO);
                    end
                    while (mag != 32'd0) begin
                        nib = mag[3:0];
                        if (nib < 4'd10) begin
                            digits.push_front(iad_pkg::CHAR_ZERO + {3'b000, nib});
                        end else begin
                            digits.push_front(iad_pkg::CHAR_LC_A + {3'b000, nib - 4'd10});
                        end
                        mag = mag >> 4;
                    end
                end
                default: begin
                    return;
                end
            endcase
            if (neg) begin
                w.ch        = iad_pkg::CHAR_MINUS;
                w.last_flag = 1'b0;
                pending_chars.push_back(w);
            end
            foreach (digits[i]) begin
                w.ch        = digits[i];
                w.last_flag = (i == digits.size() - 1);
                pending_chars.push_back(w);
            end
        endfunction

        function void check_char(logic [6:0] ch, logic last_flag);
            t_char_word w;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character %h last %b", $time, ch, last_flag);
                mismatches++;
                return;
            end
            w = pending_chars.pop_front();
            chars_checked++;
            if (ch !== w.ch) begin
                $display("%0t: character expected %h got %h", $time, w.ch, ch);
                mismatches++;
            end
            if (last_flag !== w.last_flag) begin
                $display("%0t: last flag expected %b got %b", $time, w.last_flag,
                         last_flag);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [1:0]  i_operation = 2'd0;
    logic [31:0] i_value     = 32'd0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [6:0]  o_character;
    logic        o_last_char;

    ascii_scoreboard board = new();
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              cycle_count    = 0;

    integer_to_ascii_digits_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver side: random stalls and checking of each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_char(o_character, o_last_char);
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d characters owed", $time,
                     board.pending_chars.size());
            $display("integer_to_ascii_digits_top_tb: done, errors");
            $finish;
        end
    end

    task automatic send_number(logic [1:0] op, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (!o_ready);
        board.note_number(op, val);
    endtask

    task automatic wait_all_chars();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] p;
        int          k;
        p = 32'd1;
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1000);
            2: begin
                k = $urandom_range(9);
                repeat (k) p = p * 32'd10;
                return p + $urandom_range(2) - 32'd1;
            end
            3: return 32'd1 << $urandom_range(31);
            4: return -$urandom_range(1000);
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [1:0] random_op();
        if ($urandom_range(15) == 0) begin
            return OP_UNUSED;
        end
        return 2'($urandom_range(2));
    endfunction

    int send_pct[4] = '{0, 72, 0, 16};
    int recv_pct[4] = '{0, 0, 72, 16};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // edge values for every kind
        send_number(iad_pkg::OP_UDEC, 32'd0);
        send_number(iad_pkg::OP_SDEC, 32'd0);
        send_number(iad_pkg::OP_HEX, 32'd0);
        send_number(iad_pkg::OP_UDEC, 32'hFFFF_FFFF);
        send_number(iad_pkg::OP_SDEC, 32'hFFFF_FFFF);
        send_number(iad_pkg::OP_HEX, 32'hFFFF_FFFF);
        send_number(iad_pkg::OP_SDEC, 32'h8000_0000);
        send_number(iad_pkg::OP_UDEC, 32'h8000_0000);
        send_number(iad_pkg::OP_SDEC, 32'h7FFF_FFFF);
        send_number(iad_pkg::OP_UDEC, 32'd1);
        send_number(iad_pkg::OP_UDEC, 32'd9);
        send_number(iad_pkg::OP_UDEC, 32'd10);
        send_number(iad_pkg::OP_UDEC, 32'd999999999);
        send_number(iad_pkg::OP_UDEC, 32'd1000000000);
        send_number(iad_pkg::OP_SDEC, -32'd1000000000);
        send_number(iad_pkg::OP_SDEC, 32'd1000000000);
        send_number(iad_pkg::OP_HEX, 32'hF);
        send_number(iad_pkg::OP_HEX, 32'h10);
        send_number(iad_pkg::OP_HEX, 32'hABCD_EF01);
        send_number(OP_UNUSED, 32'd0);
        send_number(OP_UNUSED, 32'hFFFF_FFFF);
        send_number(iad_pkg::OP_HEX, 32'h0123_4567);
        wait_all_chars();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_number(random_op(), random_value());
            end
            wait_all_chars();
        end

        repeat (100) @(posedge i_clk);
        $display("%0d numbers taken, %0d characters checked, %0d mismatches",
                 board.numbers_noted, board.chars_checked, board.mismatches);
        $display("covered all kinds, zero, sign extremes, unused code and four idle mixes");
        if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
            $display("integer_to_ascii_digits_top_tb: done, clean");
        end else begin
            $display("integer_to_ascii_digits_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/iad_pkg.sv
rtl/iad_ctrl.sv
rtl/iad_dpath.sv
rtl/integer_to_ascii_digits_top.sv
verif/integer_to_ascii_digits_top_tb.sv
